FILE: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/bsqe_pkg.sv
// package with transaction types and codes of the stack and queue engine
`timescale 1ns / 1ps
package bsqe_pkg;

   // operation codes
   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_LIST = 3'd1;
   localparam logic [2:0] OP_PEEK = 3'd2;
   localparam logic [2:0] OP_POP  = 3'd3;
   localparam logic [2:0] OP_SWAP = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_SHORT = 2'd2;
   localparam logic [1:0] STAT_FULL  = 2'd3;

   localparam int unsigned DATA_W = 32;

   typedef struct packed {
      logic [2:0]               mode;
      logic signed [DATA_W-1:0] value;
   } bsqe_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_res;
      logic                     has_value;
      logic [1:0]               status;
      logic                     last;
   } bsqe_rsp_type;

endpackage

FILE: sv/bsqe_index_unit.sv
// shared circular index adder: base plus offset modulo the store depth
`timescale 1ns / 1ps
module bsqe_index_unit #(
   parameter int DEPTH = 64
) (
   input  logic [$clog2(DEPTH)-1:0] base,
   input  logic [$clog2(DEPTH)-1:0] offset,
   output logic [$clog2(DEPTH)-1:0] slot
);
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W:0] SUM_DEPTH = (IDX_W+1)'(DEPTH);

   logic [IDX_W:0] sum;
   logic [IDX_W:0] wrapped;

   // both operands below depth, so one compare and subtract is enough
   always_comb begin
      sum     = {1'b0, base} + {1'b0, offset};
      wrapped = sum - SUM_DEPTH;
      if (sum >= SUM_DEPTH) begin
         slot = wrapped[IDX_W-1:0];
      end else begin
         slot = sum[IDX_W-1:0];
      end
   end
endmodule

FILE: sv/bsqe_store.sv
// entry store: single address, synchronous write, registered read
`timescale 1ns / 1ps
module bsqe_store
   import bsqe_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     wr_en,
   input  logic [DATA_W-1:0]        wr_data,
   output logic [DATA_W-1:0]        rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/bounded_stack_queue_engine_unit.sv
// top level of the bounded stack and queue engine: sequencer, state and result register
// push, pop, errors, unused codes answer in S_EXEC; peek in S_PEEK_OUT; swap in S_WR_B
// list: each entry read in S_LIST_RD and shown from S_LIST_OUT, top entry first
// busy drops in the cycle the final result is shown; only then is a new request taken
// step order set by the single port of the entry store and the one shared index adder
// reset (synchronous): list empty, order mode stack; store contents not cleared
// the receiver cannot stall: each result is valid for exactly one cycle on rsp_strobe
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bounded_stack_queue_engine_unit
   import bsqe_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   // request transaction
   input  logic         start,
   output logic         busy,
   input  bsqe_req_type req_data,
   // response transaction
   output logic         rsp_strobe,
   output bsqe_rsp_type rsp_data,
   // configuration: order mode
   input  logic         csr_we,
   input  logic         csr_wdata
);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_ZERO = '0;
   localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_PEEK_OUT,
      S_LIST_RD,
      S_LIST_OUT,
      S_RD_B,
      S_WR_A,
      S_WR_B
   } state_type;

   // sequencer and list state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             order_mode_ff, order_mode_in;
   // latched request and scratch
   logic [2:0]        op_ff, op_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]  list_idx_ff, list_idx_in;
   logic [DATA_W-1:0] tmp_ff, tmp_in;
   // response register
   logic              rsp_strobe_ff, rsp_strobe_in;
   bsqe_rsp_type      rsp_ff, rsp_in;

   // shared index adder and store hookup
   logic [IDX_W-1:0]  offset;
   logic [IDX_W-1:0]  slot;
   logic              st_wr_en;
   logic [DATA_W-1:0] st_wr_data;
   logic [DATA_W-1:0] st_rd_data;
   logic              list_last;

   bsqe_index_unit #(
      .DEPTH (DEPTH)
   ) u_index (
      .base   (top_ff),
      .offset (offset),
      .slot   (slot)
   );

   bsqe_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .addr    (slot),
      .wr_en   (st_wr_en),
      .wr_data (st_wr_data),
      .rd_data (st_rd_data)
   );

   // current list entry is the bottom one
   assign list_last = ((CNT_W'(list_idx_ff) + CNT_ONE) == count_ff);

   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      count_in      = count_ff;
      order_mode_in = csr_we ? csr_wdata : order_mode_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      list_idx_in   = list_idx_ff;
      tmp_in        = tmp_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      offset        = IDX_ZERO;
      st_wr_en      = 1'b0;
      st_wr_data    = st_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_data.mode;
               value_in = req_data.value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // single-result answer unless overridden below
            rsp_in = '{value_res: '0, has_value: 1'b0, status: STAT_OK, last: 1'b1};
            unique case (op_ff)
               OP_PUSH: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
                  if (count_ff == CNT_FULL) begin
                     rsp_in.status = STAT_FULL;
                  end else begin
                     // stack: slot above top, queue: slot below bottom
                     offset     = order_mode_ff ? IDX_LAST : count_ff[IDX_W-1:0];
                     st_wr_en   = 1'b1;
                     st_wr_data = value_ff;
                     if (order_mode_ff) begin
                        top_in = slot;
                     end
                     count_in = count_ff + CNT_ONE;
                  end
               end
               OP_LIST: begin
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     list_idx_in = IDX_ZERO;
                     state_in    = S_LIST_RD;
                  end
               end
               OP_PEEK: begin
                  if (count_ff == '0) begin
                     rsp_in.status = STAT_EMPTY;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     // store reads the top slot this cycle
                     state_in = S_PEEK_OUT;
                  end
               end
               OP_POP: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
                  if (count_ff == '0) begin
                     rsp_in.status = STAT_EMPTY;
                  end else begin
                     offset   = IDX_ONE;
                     top_in   = slot;
                     count_in = count_ff - CNT_ONE;
                  end
               end
               OP_SWAP: begin
                  if (count_ff < CNT_TWO) begin
                     rsp_in.status = STAT_SHORT;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     // top slot read this cycle
                     state_in = S_RD_B;
                  end
               end
               default: begin
                  // unused code: plain ok answer
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end
         S_PEEK_OUT: begin
            rsp_in = '{value_res: st_rd_data, has_value: 1'b1, status: STAT_OK, last: 1'b1};
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_LIST_RD: begin
            offset   = list_idx_ff;
            state_in = S_LIST_OUT;
         end
         S_LIST_OUT: begin
            rsp_in = '{value_res: st_rd_data, has_value: 1'b1, status: STAT_OK,
                       last: list_last};
            rsp_strobe_in = 1'b1;
            list_idx_in   = list_idx_ff + IDX_ONE;
            state_in      = list_last ? S_IDLE : S_LIST_RD;
         end
         S_RD_B: begin
            // top entry arrives, read the one below it
            tmp_in   = st_rd_data;
            offset   = IDX_ONE;
            state_in = S_WR_A;
         end
         S_WR_A: begin
            // second entry arrives, store it at the top slot
            offset     = IDX_ZERO;
            st_wr_en   = 1'b1;
            st_wr_data = st_rd_data;
            state_in   = S_WR_B;
         end
         S_WR_B: begin
            offset        = IDX_ONE;
            st_wr_en      = 1'b1;
            st_wr_data    = tmp_ff;
            rsp_in = '{value_res: '0, has_value: 1'b0, status: STAT_OK, last: 1'b1};
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         top_ff        <= '0;
         count_ff      <= '0;
         order_mode_ff <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         count_ff      <= count_in;
         order_mode_ff <= order_mode_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff       <= op_in;
      value_ff    <= value_in;
      list_idx_ff <= list_idx_in;
      tmp_ff      <= tmp_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // list never holds more than the store depth
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_FULL)
   // top slot always a valid store address
   `ASSERT_ALWAYS(a_top_bound, clock, reset, CNT_W'(top_ff) < CNT_FULL)
   // an accepted transaction keeps the engine busy next cycle
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // a carried value always comes with ok status
   `ASSERT_IMPLY(a_value_ok, clock, reset, rsp_strobe && rsp_data.has_value,
                 rsp_data.status == STAT_OK)
   // more list results pending keeps the engine busy
   `ASSERT_IMPLY(a_list_busy, clock, reset, rsp_strobe && !rsp_data.last, busy)
endmodule
